>>> sv/cascaded_von_neumann_byte_rng_assert.svh
// assertion macros for the cascaded von neumann byte generator
`ifndef CASCADED_VON_NEUMANN_BYTE_RNG_ASSERT_SVH
`define CASCADED_VON_NEUMANN_BYTE_RNG_ASSERT_SVH

// same-cycle implication
`define CVNBR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CVNBR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/cvnbr_pkg.sv
// package for the cascaded von neumann byte generator: widths, reset values, phase codes
package cvnbr_pkg;

  localparam int OUT_WIDTH_DEF = 8;
  localparam int BYTE_W        = 8;
  localparam int BPR_W         = 5;

  localparam logic [BPR_W-1:0] BPR_RESET = 5'd8;
  localparam logic [BPR_W-1:0] BPR_MIN   = 5'd1;

  typedef enum logic [3:0] {
    PH_WAIT_ZERO   = 4'b0001,
    PH_WAIT_ONE    = 4'b0010,
    PH_PAIR_FIRST  = 4'b0100,
    PH_PAIR_SECOND = 4'b1000
  } phase_t;

endpackage

>>> sv/cascaded_von_neumann_byte_rng.sv
// top level of the cascaded von neumann byte generator
// Takes one raw noise bit per request and runs it through two von Neumann
// debiasing stages; stage two first syncs on a 0 then a 1 from stage one, then
// keeps the second bit of the first differing pair. Conditioned bits are
// shifted in from the LSB and a byte is sent once cfg_bits_per_result bits have
// gathered (0 acts as 1, counts above 8 keep only the newest bits). One raw bit
// is accepted every cycle while no result is stalled; each request passes an input
// register and then the result register, so a byte is presented once the request
// that completes it has passed from the input register into the result register.
// A stalled result holds the input register, and new requests wait until it drains.
module cascaded_von_neumann_byte_rng #(
  parameter int OUT_WIDTH = cvnbr_pkg::OUT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_raw_bit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cvnbr_pkg::BYTE_W-1:0]  out_random_byte,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cvnbr_pkg::BPR_W-1:0]   cfg_bits_per_result
);
  import cvnbr_pkg::*;

  `include "cascaded_von_neumann_byte_rng_assert.svh"

  // only the newest SHW bits (at most a byte's worth) ever reach the output
  localparam int SHW = (OUT_WIDTH < BYTE_W) ? OUT_WIDTH : BYTE_W;

  logic [BPR_W-1:0] bpr_val_r;
  logic             in_valid_r, in_valid_nxt;
  logic             raw_r;
  logic             half_r, half_nxt;
  logic             first_r, first_nxt;
  phase_t           phase_r, phase_nxt;
  logic             s2_first_r, s2_first_nxt;
  logic [SHW-1:0]   shf_r, shf_nxt, shf_shift;
  logic [BPR_W-1:0] cnt_r, cnt_nxt, cnt_inc, need;
  logic             out_valid_r, out_valid_nxt;
  logic [SHW-1:0]   out_data_r, out_data_nxt;
  logic             adv, s1_vld, cb_vld, emit;

  assign adv       = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign need      = (bpr_val_r == '0) ? BPR_MIN : bpr_val_r;
  assign shf_shift = (shf_r << 1) | SHW'(raw_r);
  assign cnt_inc   = cnt_r + BPR_MIN;

  always_comb begin
    out_random_byte = '0;
    out_random_byte[SHW-1:0] = out_data_r;
  end

  always_comb begin
    in_valid_nxt  = in_valid_r;
    half_nxt      = half_r;
    first_nxt     = first_r;
    phase_nxt     = phase_r;
    s2_first_nxt  = s2_first_r;
    shf_nxt       = shf_r;
    cnt_nxt       = cnt_r;
    out_data_nxt  = out_data_r;
    s1_vld        = 1'b0;
    cb_vld        = 1'b0;
    emit          = 1'b0;
    if (adv) begin
      in_valid_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end
    if (adv) begin
      // stage one
      if (!half_r) begin
        first_nxt = raw_r;
        half_nxt  = 1'b1;
      end else begin
        half_nxt = 1'b0;
        s1_vld   = (first_r != raw_r);
      end
      // stage two, fed with the second raw bit
      if (s1_vld) begin
        unique case (phase_r)
          PH_WAIT_ZERO: begin
            if (!raw_r) phase_nxt = PH_WAIT_ONE;
          end
          PH_WAIT_ONE: begin
            if (raw_r) phase_nxt = PH_PAIR_FIRST;
          end
          PH_PAIR_FIRST: begin
            s2_first_nxt = raw_r;
            phase_nxt    = PH_PAIR_SECOND;
          end
          PH_PAIR_SECOND: begin
            if (s2_first_r != raw_r) begin
              cb_vld    = 1'b1;
              phase_nxt = PH_WAIT_ZERO;
            end else begin
              phase_nxt = PH_PAIR_FIRST;
            end
          end
          default: phase_nxt = PH_WAIT_ZERO;
        endcase
      end
      // assembly
      if (cb_vld) begin
        if (cnt_inc >= need) begin
          emit         = 1'b1;
          out_data_nxt = shf_shift;
          shf_nxt      = '0;
          cnt_nxt      = '0;
        end else begin
          shf_nxt = shf_shift;
          cnt_nxt = cnt_inc;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (emit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpr_val_r   <= BPR_RESET;
      in_valid_r  <= 1'b0;
      half_r      <= 1'b0;
      first_r     <= 1'b0;
      phase_r     <= PH_WAIT_ZERO;
      s2_first_r  <= 1'b0;
      shf_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) bpr_val_r <= cfg_bits_per_result;
      in_valid_r  <= in_valid_nxt;
      half_r      <= half_nxt;
      first_r     <= first_nxt;
      phase_r     <= phase_nxt;
      s2_first_r  <= s2_first_nxt;
      shf_r       <= shf_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) raw_r <= in_raw_bit;
    out_data_r <= out_data_nxt;
  end

  // assertions
  `CVNBR_ASSERT_NOW(a_emit_phase, clk, rst_n, emit,
    (phase_r == PH_PAIR_SECOND) && half_r,
    "byte completed outside the second bit of a stage-two pair")
  `CVNBR_ASSERT_NEXT(a_emit_clears, clk, rst_n, emit,
    (cnt_r == '0) && (shf_r == '0) && out_valid_r,
    "byte sent without clearing the count")
  `CVNBR_ASSERT_NEXT(a_hold_input, clk, rst_n, in_valid_r && !adv,
    in_valid_r && $stable(raw_r),
    "stalled request lost from the input register")
  `CVNBR_ASSERT_NEXT(a_hold_output, clk, rst_n, out_valid_r && !out_ready,
    out_valid_r && $stable(out_data_r),
    "waiting byte changed before it was taken")

endmodule

>>> test/cascaded_von_neumann_byte_rng_tb.sv
// testbench for the cascaded von neumann byte generator: raw bit stimulus and byte scoreboard
module cascaded_von_neumann_byte_rng_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cvnbr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_raw_bit = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [BYTE_W-1:0]   out_random_byte;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [BPR_W-1:0]    cfg_bits_per_result = '0;

  int                  idle_pct = 0;
  int                  items_sent = 0;
  int                  cycles = 0;

  class byte_scoreboard;
    logic [BPR_W-1:0]  count_reg;
    logic              raw_half;
    logic              raw_first;
    phase_t            phase;
    logic              pair_first;
    logic [BYTE_W-1:0] shifter;
    logic [BPR_W-1:0]  gathered;
    int                cond_bits;
    logic [BYTE_W-1:0] pending_bytes[$];
    int                errors;

    function new();
      count_reg  = BPR_RESET;
      raw_half   = 1'b0;
      raw_first  = 1'b0;
      phase      = PH_WAIT_ZERO;
      pair_first = 1'b0;
      shifter    = '0;
      gathered   = '0;
      cond_bits  = 0;
      errors     = 0;
    endfunction

    function void set_count(logic [BPR_W-1:0] v);
      count_reg = v;
    endfunction

    function void note_raw(logic b);
      logic             got_bit;
      logic [BPR_W-1:0] need;
      got_bit = 1'b0;
      if (!raw_half) begin
        raw_first = b;
        raw_half  = 1'b1;
        return;
      end
      raw_half = 1'b0;
      if (raw_first == b) return;
      case (phase)
        PH_WAIT_ZERO: begin
          if (!b) phase = PH_WAIT_ONE;
        end
        PH_WAIT_ONE: begin
          if (b) phase = PH_PAIR_FIRST;
        end
        PH_PAIR_FIRST: begin
          pair_first = b;
          phase      = PH_PAIR_SECOND;
        end
        default: begin
          if (pair_first != b) begin
            got_bit = 1'b1;
            phase   = PH_WAIT_ZERO;
          end else begin
            phase = PH_PAIR_FIRST;
          end
        end
      endcase
      if (!got_bit) return;
      cond_bits++;
      shifter  = {shifter[BYTE_W-2:0], b};
      gathered = gathered + 1'b1;
      need     = (count_reg == '0) ? BPR_MIN : count_reg;
      if (gathered >= need) begin
        pending_bytes.push_back(shifter);
        shifter  = '0;
        gathered = '0;
      end
    endfunction

    task flag(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_byte(logic [BYTE_W-1:0] got);
      logic [BYTE_W-1:0] want;
      if (pending_bytes.size() == 0) begin
        flag($sformatf("byte %02h with none expected", got));
        return;
      end
      want = pending_bytes.pop_front();
      if (got !== want) flag($sformatf("random_byte %02h, expected %02h", got, want));
    endtask
  endclass

  byte_scoreboard sb = new();

  cascaded_von_neumann_byte_rng u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_raw_bit          (in_raw_bit),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_random_byte     (out_random_byte),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_bits_per_result (cfg_bits_per_result)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("cascaded_von_neumann_byte_rng_tb NOT OK");
      $finish;
    end
  end

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_byte(out_random_byte);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
        stall_left = $urandom_range(4, 1) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_raw(logic b);
    int gap;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(4, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_raw_bit <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_raw(b);
    items_sent++;
  endtask

  // pause the sender until every expected byte is back, then let the pipeline empty
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_count(logic [BPR_W-1:0] v);
    cfg_valid           <= 1'b1;
    cfg_bits_per_result <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_count(v);
    cfg_valid <= 1'b0;
  endtask

  // steer stage-one bits through sync and pairing until one conditioned bit comes out or the guard of 40 tries runs out
  task automatic make_conditioned_bit();
    int   start_bits;
    int   guard;
    logic s1;
    logic b;
    start_bits = sb.cond_bits;
    guard      = 0;
    if (sb.raw_half) send_raw(1'($urandom_range(1)));
    while (sb.cond_bits == start_bits && guard < 40) begin
      guard++;
      if ($urandom_range(9) == 0) begin
        b = 1'($urandom_range(1));
        send_raw(b);
        send_raw(b);
      end
      case (sb.phase)
        PH_WAIT_ZERO:  s1 = ($urandom_range(3) == 0);
        PH_WAIT_ONE:   s1 = ($urandom_range(3) != 0);
        PH_PAIR_FIRST: s1 = 1'($urandom_range(1));
        default:       s1 = ($urandom_range(3) == 0) ? sb.pair_first : ~sb.pair_first;
      endcase
      send_raw(~s1);
      send_raw(s1);
    end
  endtask

  initial begin : stimulus
    logic [23:0]      directed_bits = 24'b001101101001010110011001;
    logic [BPR_W-1:0] count_plan[10] = '{5'd0, 5'd31, 5'd1, 5'd16, 5'd2,
                                         5'd5, 5'd3, 5'd4, 5'd1, 5'd8};
    int               phase_len[10] = '{110, 350, 110, 110, 110, 110, 110, 110, 110, 110};
    int               stop_at;
    int               burst;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // dropped pairs, sync waits, an equal second-stage pair, then one conditioned bit
    for (int i = 23; i >= 0; i--) send_raw(directed_bits[i]);

    for (int p = 0; p < 10; p++) begin
      drain_results();
      write_count(count_plan[p]);
      idle_pct = (p == 9 || p % 3 == 1) ? 0 : 30;
      stop_at  = items_sent + phase_len[p];
      while (items_sent < stop_at) begin
        if ($urandom_range(3) == 0) begin
          burst = $urandom_range(8, 1);
          repeat (burst) send_raw(1'($urandom_range(1)));
        end else begin
          make_conditioned_bit();
        end
        if ($urandom_range(299) == 0) drain_results();
      end
    end

    in_valid <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.pending_bytes.size() != 0)
      sb.flag($sformatf("%0d bytes never arrived", sb.pending_bytes.size()));
    if (sb.errors == 0) begin
      $display("cascaded_von_neumann_byte_rng_tb OK");
    end else begin
      $display("cascaded_von_neumann_byte_rng_tb NOT OK");
    end
    $finish;
  end

endmodule
